[sv/gfap_pkg.sv]
// Package: field element type, pipeline item type, GF(2^83) arithmetic and inversion schedule.
`default_nettype none
package gfap_pkg;

    localparam int FieldBits = 83;
    localparam int LowBits   = 64;
    localparam int HighBits  = FieldBits - LowBits;
    localparam int ProdBits  = 2 * FieldBits - 1;
    localparam int InvStages = 19;
    localparam int MaxSq     = 8;

    typedef logic [FieldBits-1:0] fe_t;

    typedef enum logic [1:0] {
        MS_NONE,
        MS_A,
        MS_S
    } mul_sel_t;

    // one item in flight
    typedef struct packed {
        logic byp;   // special case, coordinates pass straight out
        logic dbl;   // equal points, doubling
        logic inf;   // result at infinity
        fe_t  px;
        fe_t  py;
        fe_t  d;     // denominator, inversion input
        fe_t  n;     // numerator
        fe_t  t;     // running chain value
        fe_t  s;     // last saved chain value
    } pipe_t;

    // Itoh-Tsujii chain, one row per stage: squarings then optional multiply
    localparam int unsigned INV_SQ [InvStages] =
        '{1, 2, 1, 4, 1, 8, 2, 8, 8, 4, 0, 1, 8, 8, 8, 8, 8, 1, 1};
    localparam mul_sel_t INV_MUL [InvStages] =
        '{MS_A, MS_S, MS_A, MS_NONE, MS_S, MS_NONE, MS_S, MS_NONE, MS_NONE,
          MS_NONE, MS_S, MS_A, MS_NONE, MS_NONE, MS_NONE, MS_NONE, MS_NONE,
          MS_S, MS_NONE};

    // fold z^83 = z^7 + z^4 + z^2 + 1, twice
    function automatic fe_t gf_reduce(input logic [ProdBits-1:0] c);
        logic [81:0] h;
        logic [88:0] t;
        logic [5:0]  h2;
        fe_t         r;
        h  = c[ProdBits-1:FieldBits];
        t  = {6'b0, c[FieldBits-1:0]} ^ {7'b0, h} ^ {5'b0, h, 2'b0}
           ^ {3'b0, h, 4'b0} ^ {h, 7'b0};
        h2 = t[88:83];
        r  = t[82:0] ^ {77'b0, h2} ^ {75'b0, h2, 2'b0} ^ {73'b0, h2, 4'b0}
           ^ {70'b0, h2, 7'b0};
        return r;
    endfunction

    function automatic fe_t gf_mul(input fe_t a, input fe_t b);
        logic [ProdBits-1:0] c;
        c = '0;
        for (int i = 0; i < FieldBits; i++) begin
            if (b[i]) begin
                c = c ^ ({{(FieldBits-1){1'b0}}, a} << i);
            end
        end
        return gf_reduce(c);
    endfunction

    function automatic fe_t gf_sqr(input fe_t a);
        logic [ProdBits-1:0] c;
        c = '0;
        for (int i = 0; i < FieldBits; i++) begin
            c[2*i] = a[i];
        end
        return gf_reduce(c);
    endfunction

    function automatic fe_t gf_sqrn(input fe_t a, input int unsigned k);
        fe_t r;
        r = a;
        for (int unsigned i = 0; i < MaxSq; i++) begin
            if (i < k) begin
                r = gf_sqr(r);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[sv/gfap_inv_pipe.sv]
// Pipelined field inversion, a^(2^83-2), one item per cycle.
`default_nettype none
module gfap_inv_pipe (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_vld,
    input  wire gfap_pkg::pipe_t in_item,
    output logic                out_vld,
    output gfap_pkg::pipe_t     out_item
);

    logic            vld_reg  [gfap_pkg::InvStages+1];
    gfap_pkg::pipe_t item_reg [gfap_pkg::InvStages+1];

    assign vld_reg[0]  = in_vld;
    assign item_reg[0] = in_item;

    for (genvar g = 0; g < gfap_pkg::InvStages; g++) begin : g_stage
        gfap_pkg::pipe_t item_next;
        gfap_pkg::fe_t   sq;

        always_comb
        begin
            item_next = item_reg[g];
            sq        = gfap_pkg::gf_sqrn(item_reg[g].t, gfap_pkg::INV_SQ[g]);
            case (gfap_pkg::INV_MUL[g])
                gfap_pkg::MS_A:
                begin
                    item_next.t = gfap_pkg::gf_mul(sq, item_reg[g].d);
                    item_next.s = item_next.t;
                end
                gfap_pkg::MS_S:
                begin
                    item_next.t = gfap_pkg::gf_mul(sq, item_reg[g].s);
                    item_next.s = item_next.t;
                end
                default:
                begin
                    item_next.t = sq;
                end
            endcase
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                vld_reg[g+1] <= 1'b0;
            end else begin
                vld_reg[g+1] <= vld_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            item_reg[g+1] <= item_next;
        end
    end

    assign out_vld  = vld_reg[gfap_pkg::InvStages];
    assign out_item = item_reg[gfap_pkg::InvStages];

endmodule
`default_nettype wire

[sv/binary_curve_point_add_unit.sv]
// Top level: pipelined affine point addition on a binary curve over GF(2^83).
// Pipeline: 1 classify stage, 19 inversion stages, 3 stages for lambda, x and y; done
//   rises together with the result in the output registers.
// Throughput: one item per cycle; busy is held low, the pipeline never stalls.
// Reset: rst_n clears every valid bit at once; items in flight are dropped.
`default_nettype none
module binary_curve_point_add_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] p_x_low,
    input  wire logic [18:0] p_x_high,
    input  wire logic [63:0] p_y_low,
    input  wire logic [18:0] p_y_high,
    input  wire logic        p_at_infinity,
    input  wire logic [63:0] q_x_low,
    input  wire logic [18:0] q_x_high,
    input  wire logic [63:0] q_y_low,
    input  wire logic [18:0] q_y_high,
    input  wire logic        q_at_infinity,
    output logic             done,
    output logic [63:0]      sum_x_low,
    output logic [18:0]      sum_x_high,
    output logic [63:0]      sum_y_low,
    output logic [18:0]      sum_y_high,
    output logic             sum_at_infinity
);

    // ---------------- classify stage ----------------
    gfap_pkg::fe_t   px, py, qx, qy;
    logic            eq_x, eq_y;
    gfap_pkg::pipe_t front_next, front_reg;
    logic            front_vld_reg;

    assign px = {p_x_high, p_x_low};
    assign py = {p_y_high, p_y_low};
    assign qx = {q_x_high, q_x_low};
    assign qy = {q_y_high, q_y_low};
    assign eq_x = (px == qx);
    assign eq_y = (py == qy);

    always_comb
    begin
        front_next     = '0;
        front_next.dbl = eq_x;
        front_next.d   = eq_x ? px : (px ^ qx);
        front_next.n   = eq_x ? py : (py ^ qy);
        front_next.t   = front_next.d;
        front_next.s   = front_next.d;
        front_next.px  = px;
        front_next.py  = py;
        if (p_at_infinity) begin
            // the other operand passes through; coordinates zero at infinity
            front_next.byp = 1'b1;
            front_next.inf = q_at_infinity;
            front_next.px  = q_at_infinity ? '0 : qx;
            front_next.py  = q_at_infinity ? '0 : qy;
        end else if (q_at_infinity) begin
            front_next.byp = 1'b1;
        end else if (eq_x && (!eq_y || (px == '0))) begin
            // inverse points, or doubling with a vertical tangent
            front_next.byp = 1'b1;
            front_next.inf = 1'b1;
            front_next.px  = '0;
            front_next.py  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            front_vld_reg <= 1'b0;
        end else begin
            front_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
    end

    // ---------------- inversion of the denominator ----------------
    logic            inv_vld;
    gfap_pkg::pipe_t inv_item;

    gfap_inv_pipe u_inv (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (front_vld_reg),
        .in_item  (front_reg),
        .out_vld  (inv_vld),
        .out_item (inv_item)
    );

    // ---------------- lambda: n / d, plus x for doubling ----------------
    gfap_pkg::pipe_t lam_next, lam_reg;
    logic            lam_vld_reg;

    always_comb
    begin
        lam_next   = inv_item;
        lam_next.t = gfap_pkg::gf_mul(inv_item.n, inv_item.t)
                   ^ (inv_item.dbl ? inv_item.px : '0);
    end

    // ---------------- x: lambda^2 + lambda (+ d on a chord) ----------------
    gfap_pkg::pipe_t rx_next, rx_reg;
    logic            rx_vld_reg;

    always_comb
    begin
        rx_next   = lam_reg;
        rx_next.s = gfap_pkg::gf_sqr(lam_reg.t) ^ lam_reg.t
                  ^ (lam_reg.dbl ? '0 : lam_reg.d);
        // multiplier operand for y
        rx_next.n = lam_reg.dbl ? rx_next.s : (lam_reg.px ^ rx_next.s);
    end

    // ---------------- y and output register ----------------
    gfap_pkg::fe_t ry, out_x_next, out_y_next, out_x_reg, out_y_reg;
    logic          out_inf_reg, done_reg;

    always_comb
    begin
        ry = gfap_pkg::gf_mul(rx_reg.t, rx_reg.n) ^ rx_reg.s
           ^ (rx_reg.dbl ? gfap_pkg::gf_sqr(rx_reg.px) : rx_reg.py);
        out_x_next = rx_reg.byp ? rx_reg.px : rx_reg.s;
        out_y_next = rx_reg.byp ? rx_reg.py : ry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lam_vld_reg <= 1'b0;
            rx_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            lam_vld_reg <= inv_vld;
            rx_vld_reg  <= lam_vld_reg;
            done_reg    <= rx_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lam_reg     <= lam_next;
        rx_reg      <= rx_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
        out_inf_reg <= rx_reg.inf;
    end

    assign busy            = 1'b0;
    assign done            = done_reg;
    assign sum_x_low       = out_x_reg[gfap_pkg::LowBits-1:0];
    assign sum_x_high      = out_x_reg[gfap_pkg::FieldBits-1:gfap_pkg::LowBits];
    assign sum_y_low       = out_y_reg[gfap_pkg::LowBits-1:0];
    assign sum_y_high      = out_y_reg[gfap_pkg::FieldBits-1:gfap_pkg::LowBits];
    assign sum_at_infinity = out_inf_reg;

endmodule
`default_nettype wire

[sv/gfap_checker.sv]
// Port-level checker for the point addition unit, bound to the top level.
`default_nettype none
module gfap_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        p_at_infinity,
    input wire logic        q_at_infinity,
    input wire logic        done,
    input wire logic [63:0] sum_x_low,
    input wire logic [18:0] sum_x_high,
    input wire logic [63:0] sum_y_low,
    input wire logic [18:0] sum_y_high,
    input wire logic        sum_at_infinity
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##23 done)
        else $error("item not delivered after 23 cycles");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 23))
        else $error("result without an item");

    a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && sum_at_infinity |-> sum_x_low == 64'd0 && sum_x_high == 19'd0
            && sum_y_low == 64'd0 && sum_y_high == 19'd0)
        else $error("infinity with nonzero coordinates");

    a_both_inf: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && p_at_infinity && q_at_infinity |-> ##23 sum_at_infinity)
        else $error("infinity plus infinity not infinity");

endmodule

bind binary_curve_point_add_unit gfap_checker u_gfap_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .p_at_infinity   (p_at_infinity),
    .q_at_infinity   (q_at_infinity),
    .done            (done),
    .sum_x_low       (sum_x_low),
    .sum_x_high      (sum_x_high),
    .sum_y_low       (sum_y_low),
    .sum_y_high      (sum_y_high),
    .sum_at_infinity (sum_at_infinity)
);
`default_nettype wire
